[rtl/assert_macros.svh]
// Concurrent assertion helpers, sampled on clk and off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define AST_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/efd_pkg.sv]
package efd_pkg;

  // Default width of the little-endian length field, in bytes (1 to 4).
  localparam int LENGTH_FIELD_BYTES = 4;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] ESCAPE_RST = 8'd255;
  localparam logic [7:0] START_RST  = 8'd253;
  localparam logic [7:0] NOP_RST    = 8'd254;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ESCAPE = 2'd0,
    CFG_START  = 2'd1,
    CFG_NOP    = 2'd2
  } cfg_idx_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_CRC_GOOD   = 3'd1,
    EV_CRC_BAD    = 3'd2,
    EV_BAD_ESCAPE = 3'd3,
    EV_SHORT      = 3'd4
  } event_t;

  // CRC-16-CCITT, one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the escape byte alone, at the reset escape code.
  localparam logic [15:0] SEED_ESC_RST = crc_byte(CRC_INIT, ESCAPE_RST);

endpackage

[rtl/escaped_frame_deframer_crc16.sv]
// A byte in the input register is stepped, and any result loaded, once the output register is free.
// Throughput: one wire byte per cycle while out_stall is low; the input register and the
// result register each hold one beat, with the per-byte CRC update and state step between them.
// Reset: synchronous rst returns to hunting, clears escape and counters, CRC to 0xffff,
// and restores escape 255, start 253, nop 254. Configuration is ready at all times.
`include "assert_macros.svh"

module escaped_frame_deframer_crc16 #(
  parameter int LENGTH_FIELD_BYTES = efd_pkg::LENGTH_FIELD_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] wire_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] payload_byte,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int LenW = 8 * LENGTH_FIELD_BYTES;
  localparam int CntW = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(LENGTH_FIELD_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  // configuration
  logic [7:0]  escape_code, start_code, nop_code;
  logic [15:0] seed_esc, seed;

  // input register
  logic        in_q_valid;
  logic [7:0]  byte_q;

  // deframer state
  phase_t          phase, phase_next;
  logic            escape_pending, escape_pending_next;
  logic [15:0]     running_crc, running_crc_next;
  logic [CntW-1:0] field_count, field_count_next;
  logic            crc_count, crc_count_next;
  logic [7:0]      crc_lo, crc_lo_next;
  logic [LenW-1:0] payload_left, payload_left_next;

  // result register
  efd_pkg::event_t out_event;
  logic [7:0]      out_byte;

  // step outputs
  logic            res_valid;
  efd_pkg::event_t res_event;
  logic [7:0]      res_byte;
  logic            advance;
  logic [15:0]     crc_upd;
  logic            is_esc, is_start, is_nop;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = rst || (in_q_valid && !advance);

  assign event_res    = out_event;
  assign payload_byte = out_byte;

  // Packet-start seed follows the current escape and start codes.
  assign seed = efd_pkg::crc_byte(seed_esc, start_code);

  assign crc_upd  = efd_pkg::crc_byte(running_crc, byte_q);
  assign is_esc   = (byte_q == escape_code);
  assign is_start = (byte_q == start_code);
  assign is_nop   = (byte_q == nop_code);

  // One deframer step for the byte in the input register.
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    running_crc_next    = running_crc;
    field_count_next    = field_count;
    crc_count_next      = crc_count;
    crc_lo_next         = crc_lo;
    payload_left_next   = payload_left;
    res_valid           = 1'b0;
    res_event           = efd_pkg::EV_PAYLOAD;
    res_byte            = 8'h00;

    if (phase == PH_HUNT) begin
      // hunt for escape then start
      if (is_esc) begin
        escape_pending_next = 1'b1;
      end else if (is_start && escape_pending) begin
        phase_next          = PH_LENGTH;
        escape_pending_next = 1'b0;
        running_crc_next    = seed;
        field_count_next    = '0;
        crc_count_next      = 1'b0;
        payload_left_next   = '0;
      end else begin
        escape_pending_next = 1'b0;
      end
    end else if (escape_pending && is_start) begin
      // reopen: short packet
      phase_next          = PH_LENGTH;
      escape_pending_next = 1'b0;
      running_crc_next    = seed;
      field_count_next    = '0;
      crc_count_next      = 1'b0;
      payload_left_next   = '0;
      res_valid           = 1'b1;
      res_event           = efd_pkg::EV_SHORT;
    end else if (escape_pending && is_nop) begin
      // drop escaped nop
      escape_pending_next = 1'b0;
      if (phase != PH_CRC) running_crc_next = crc_upd;
    end else if (escape_pending && !is_esc) begin
      // invalid escape: back to hunting
      escape_pending_next = 1'b0;
      phase_next          = PH_HUNT;
      field_count_next    = '0;
      crc_count_next      = 1'b0;
      res_valid           = 1'b1;
      res_event           = efd_pkg::EV_BAD_ESCAPE;
    end else if (!escape_pending && is_esc) begin
      // open an escape
      escape_pending_next = 1'b1;
      if (phase != PH_CRC) running_crc_next = crc_upd;
    end else begin
      // literal byte (plain, or escape-escape)
      escape_pending_next = 1'b0;
      if (phase != PH_CRC) running_crc_next = crc_upd;
      unique case (phase)
        PH_LENGTH: begin
          for (int i = 0; i < LENGTH_FIELD_BYTES; i++) begin
            if (field_count == CntW'(i)) payload_left_next[8*i +: 8] = payload_left[8*i +: 8] | byte_q;
          end
          if (field_count == CntLast) begin
            field_count_next = '0;
            crc_count_next   = 1'b0;
            phase_next       = (payload_left_next != '0) ? PH_PAYLOAD : PH_CRC;
          end else begin
            field_count_next = field_count + CntW'(1);
          end
        end
        PH_PAYLOAD: begin
          payload_left_next = payload_left - LenW'(1);
          if (payload_left_next == '0) begin
            phase_next     = PH_CRC;
            crc_count_next = 1'b0;
          end
          res_valid = 1'b1;
          res_event = efd_pkg::EV_PAYLOAD;
          res_byte  = byte_q;
        end
        PH_CRC: begin
          if (!crc_count) begin
            crc_lo_next    = byte_q;
            crc_count_next = 1'b1;
          end else begin
            crc_count_next = 1'b0;
            phase_next     = PH_HUNT;
            res_valid      = 1'b1;
            res_event      = ({byte_q, crc_lo} == running_crc) ? efd_pkg::EV_CRC_GOOD
                                                                : efd_pkg::EV_CRC_BAD;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Configuration registers and the CRC after the escape byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code <= efd_pkg::ESCAPE_RST;
      start_code  <= efd_pkg::START_RST;
      nop_code    <= efd_pkg::NOP_RST;
      seed_esc    <= efd_pkg::SEED_ESC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        efd_pkg::CFG_ESCAPE: begin
          escape_code <= cfg_data;
          seed_esc    <= efd_pkg::crc_byte(efd_pkg::CRC_INIT, cfg_data);
        end
        efd_pkg::CFG_START: start_code <= cfg_data;
        efd_pkg::CFG_NOP:   nop_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: take a beat whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_q <= wire_byte;
  end

  // Deframer state: advance one byte per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      escape_pending <= 1'b0;
      running_crc    <= efd_pkg::CRC_INIT;
      field_count    <= '0;
      crc_count      <= 1'b0;
      payload_left   <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      running_crc    <= running_crc_next;
      field_count    <= field_count_next;
      crc_count      <= crc_count_next;
      payload_left   <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) crc_lo <= crc_lo_next;
  end

  // Result register: load on a producing step, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_event <= res_event;
      out_byte  <= res_byte;
    end
  end

  `AST_IMPLIES(a_payload_left_live, phase == PH_PAYLOAD, payload_left != '0, "payload phase with zero bytes left")
  `AST_IMPLIES(a_crc_event_phase, advance && res_valid && (res_event == efd_pkg::EV_CRC_GOOD || res_event == efd_pkg::EV_CRC_BAD), phase == PH_CRC, "crc verdict outside crc field")
  `AST_IMPLIES(a_no_overwrite, advance && res_valid, !out_valid || !out_stall, "result register overwritten while held")
  `AST_HOLDS(a_byte_zero, !out_valid || out_event == efd_pkg::EV_PAYLOAD || out_byte == 8'h00, "data byte set on a non-payload event")

endmodule
